[rtl/lrbt_pkg.sv]
// ----------------------------------------------------------------------------
// lrbt_pkg
// Shared types and constants of the link retry backoff timer.
// ----------------------------------------------------------------------------
`default_nettype none

package lrbt_pkg;

  // widths of the fixed-size fields
  localparam int unsigned MsW     = 32;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_BACKOFF = 2'd0,
    CFG_MAX_BACKOFF   = 2'd1,
    CFG_GRACE         = 2'd2
  } cfg_idx_e;

  // register reset values
  localparam logic [MsW-1:0] FirstBackoffRst = 32'd5000;
  localparam logic [MsW-1:0] MaxBackoffRst   = 32'd300000;
  localparam logic [MsW-1:0] GraceRst        = 32'd10000;

  // configuration settings seen by the step logic
  typedef struct packed {
    logic [MsW-1:0] first_backoff_ms;
    logic [MsW-1:0] max_backoff_ms;
    logic [MsW-1:0] grace_ms;
  } cfg_t;

  // one result word
  typedef struct packed {
    logic           reconnect_now;
    logic [MsW-1:0] ms_until_next;
    logic [MsW-1:0] attempt_count;
  } result_t;

endpackage

`default_nettype wire

[rtl/link_retry_backoff_timer.sv]
// ----------------------------------------------------------------------------
// link_retry_backoff_timer
// Capped exponential backoff for link reconnect attempts.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  in       | input     | in_valid_i/in_ready_o  | link_up_i, now_ms_i
//  out      | output    | out_valid_o/out_ready_i| reconnect_now_o, ms_until_next_o,
//           |           |                        | attempt_count_o
//  cfg      | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// one word in, one word out; a word is taken every cycle when the output flows
// each word passes the input register, then the step logic into the result register
// the input register refills in the cycle the result register is taken
// reset restores the register defaults and the link-up state
// ----------------------------------------------------------------------------
`default_nettype none

module link_retry_backoff_timer #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire                               link_up_i,
  input  wire [lrbt_pkg::MsW-1:0]           now_ms_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic                              reconnect_now_o,
  output logic [lrbt_pkg::MsW-1:0]          ms_until_next_o,
  output logic [lrbt_pkg::MsW-1:0]          attempt_count_o,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire [lrbt_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire [lrbt_pkg::MsW-1:0]           cfg_data_i
);

  lrbt_pkg::cfg_t           cfg_q;
  logic                     in_valid_q;
  logic                     link_up_q;
  logic [lrbt_pkg::MsW-1:0] now_q;
  logic                     out_valid_q;
  lrbt_pkg::result_t        res_q;
  lrbt_pkg::result_t        res_d;
  logic                     link_down_q, link_down_d;
  logic [lrbt_pkg::MsW-1:0] attempts_q, attempts_d;
  logic [TIME_WIDTH-1:0]    deadline_q, deadline_d;
  logic [lrbt_pkg::MsW-1:0] backoff_q, backoff_d;
  logic                     adv;

  // handshake
  assign adv         = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || adv;
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_backoff_ms <= lrbt_pkg::FirstBackoffRst;
      cfg_q.max_backoff_ms   <= lrbt_pkg::MaxBackoffRst;
      cfg_q.grace_ms         <= lrbt_pkg::GraceRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lrbt_pkg::CFG_FIRST_BACKOFF: cfg_q.first_backoff_ms <= cfg_data_i;
        lrbt_pkg::CFG_MAX_BACKOFF:   cfg_q.max_backoff_ms   <= cfg_data_i;
        lrbt_pkg::CFG_GRACE:         cfg_q.grace_ms         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      link_up_q <= link_up_i;
      now_q     <= now_ms_i;
    end
  end

  // step logic
  lrbt_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .link_up_i   (link_up_q),
    .now_ms_i    (now_q),
    .cfg_i       (cfg_q),
    .link_down_i (link_down_q),
    .attempts_i  (attempts_q),
    .deadline_i  (deadline_q),
    .backoff_i   (backoff_q),
    .link_down_o (link_down_d),
    .attempts_o  (attempts_d),
    .deadline_o  (deadline_d),
    .backoff_o   (backoff_d),
    .result_o    (res_d)
  );

  // timer state, updated as each word moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_down_q <= 1'b0;
      attempts_q  <= '0;
      deadline_q  <= '0;
      backoff_q   <= '0;
    end else if (adv) begin
      link_down_q <= link_down_d;
      attempts_q  <= attempts_d;
      deadline_q  <= deadline_d;
      backoff_q   <= backoff_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign reconnect_now_o = res_q.reconnect_now;
  assign ms_until_next_o = res_q.ms_until_next;
  assign attempt_count_o = res_q.attempt_count;

  // a fired attempt always reports a nonzero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.reconnect_now |-> res_q.attempt_count != '0)
    else $error("reconnect reported with zero attempt count");

  // a link-up sample clears the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && link_up_q |=> !res_q.reconnect_now && res_q.attempt_count == '0
                         && res_q.ms_until_next == '0)
    else $error("link-up sample gave a nonzero result");

  // no attempts are counted while the link is considered up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !link_down_q |-> attempts_q == '0)
    else $error("attempt count nonzero while link up");

endmodule

`default_nettype wire

[rtl/lrbt_step.sv]
// ----------------------------------------------------------------------------
// lrbt_step
// Next-state and result logic for one link sample: arm, fire and re-arm.
// ----------------------------------------------------------------------------
`default_nettype none

module lrbt_step #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire                          link_up_i,
  input  wire [lrbt_pkg::MsW-1:0]      now_ms_i,
  input  wire lrbt_pkg::cfg_t          cfg_i,
  input  wire                          link_down_i,
  input  wire [lrbt_pkg::MsW-1:0]      attempts_i,
  input  wire [TIME_WIDTH-1:0]         deadline_i,
  input  wire [lrbt_pkg::MsW-1:0]      backoff_i,
  output logic                         link_down_o,
  output logic [lrbt_pkg::MsW-1:0]     attempts_o,
  output logic [TIME_WIDTH-1:0]        deadline_o,
  output logic [lrbt_pkg::MsW-1:0]     backoff_o,
  output lrbt_pkg::result_t            result_o
);

  logic [TIME_WIDTH-1:0]    now_t;
  logic [TIME_WIDTH-1:0]    diff;
  logic                     hit;
  logic [lrbt_pkg::MsW-1:0] attempts_inc;
  logic [lrbt_pkg::MsW-1:0] backoff_nxt;
  logic [TIME_WIDTH-1:0]    arm_delay;
  logic [TIME_WIDTH-1:0]    arm_neg;

  // wrap-safe deadline check on the current deadline
  assign now_t = TIME_WIDTH'(now_ms_i);
  assign diff  = now_t - deadline_i;
  assign hit   = ~diff[TIME_WIDTH-1];

  // saturating attempt count
  assign attempts_inc = (&attempts_i) ? attempts_i : attempts_i + 1'b1;

  // capped doubling of the running backoff
  always_comb begin
    if (attempts_i == '0) begin
      backoff_nxt = cfg_i.first_backoff_ms;
    end else if (backoff_i >= (cfg_i.max_backoff_ms >> 1)) begin
      backoff_nxt = cfg_i.max_backoff_ms;
    end else begin
      backoff_nxt = backoff_i << 1;
    end
  end

  // delay to a freshly armed deadline, and whether it is already due
  assign arm_delay = link_down_i ? TIME_WIDTH'(backoff_nxt) : TIME_WIDTH'(cfg_i.grace_ms);
  assign arm_neg   = '0 - arm_delay;

  // state update and result
  always_comb begin
    link_down_o = link_down_i;
    attempts_o  = attempts_i;
    deadline_o  = deadline_i;
    backoff_o   = backoff_i;
    result_o    = '0;
    if (link_up_i) begin
      link_down_o = 1'b0;
      attempts_o  = '0;
    end else if (!link_down_i || hit) begin
      // arm after the drop, or fire and re-arm
      deadline_o = now_t + arm_delay;
      if (!link_down_i) begin
        link_down_o = 1'b1;
        attempts_o  = '0;
        backoff_o   = '0;
      end else begin
        attempts_o             = attempts_inc;
        backoff_o              = backoff_nxt;
        result_o.reconnect_now = 1'b1;
      end
      if (arm_neg[TIME_WIDTH-1]) begin
        result_o.ms_until_next = lrbt_pkg::MsW'(arm_delay);
      end
    end else begin
      // still waiting on the deadline
      result_o.ms_until_next = lrbt_pkg::MsW'(deadline_i - now_t);
    end
    result_o.attempt_count = attempts_o;
  end

endmodule

`default_nettype wire
